[hdl/stk_pkg.sv]
// Shared types and constants for the S-expression tokenizer.
// Used by stk_scan, stk_out_pair, sexpr_tokenizer_unit, token_checker and tb; no dependencies.
package stk_pkg;

  // Scanner modes
  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_TOKEN   = 2'd1,
    MODE_ESCAPE  = 2'd2,
    MODE_COMMENT = 2'd3
  } scan_mode_t;

  // Result kinds
  typedef enum logic [3:0] {
    KIND_OPEN      = 4'd0,
    KIND_CLOSE     = 4'd1,
    KIND_QUOTE     = 4'd2,
    KIND_BACKQUOTE = 4'd3,
    KIND_COMMA     = 4'd4,
    KIND_CHAR      = 4'd5,
    KIND_DOT       = 4'd6,
    KIND_NUMBER    = 4'd7,
    KIND_SYMBOL    = 4'd8,
    KIND_END       = 4'd9
  } kind_t;

  // Character codes
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  // Limits
  localparam int unsigned NUM_W    = 63;
  localparam int unsigned FRAC_W   = 5;
  localparam int unsigned LINE_W   = 16;
  localparam logic [NUM_W-1:0]  NUM_MAX  = {NUM_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd18;
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [1:0]        DOT_MAX  = 2'd2;

  // One result beat
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         ch;
    logic [NUM_W-1:0]   num;
    logic [FRAC_W-1:0]  frac;
    logic               ovf;
    logic               too_long;
    logic [LINE_W-1:0]  line;
  } result_t;

  // Results of one input item: a full first beat and, when count is two,
  // a second beat that carries only a kind
  typedef struct packed {
    result_t     first;
    kind_t       second_kind;
    logic [1:0]  count;
  } scan_out_t;

endpackage

[hdl/sexpr_tokenizer_unit.sv]
// Top level of the S-expression tokenizer: input register, scanner, output pair.
// Depends on stk_pkg, stk_scan and stk_out_pair.
//
// Takes one source byte (or an end-of-input mark) per beat and returns its
// tokens: single-character specials, one beat per token character, a class
// beat (dot, number with fraction digit count, or symbol) at token end and an
// end beat per end mark, with the current line number on every beat and
// out_last on the final beat of each input. A byte passes from the input
// register through the scanner into the output register once that is free,
// and its first result beat is then offered. The block takes one byte per
// cycle while the receiver takes every beat; a byte giving two results (a
// token ended by a special character, or end of input inside a token) holds
// the output register for two beats, so the input side waits for the second.
// Bytes giving no result still step the scanner; no clearing pass follows reset.
module sexpr_tokenizer_unit
  import stk_pkg::*;
#(
  parameter int unsigned MAX_TOKEN = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_at_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_kind,
  output logic [7:0]         out_char,
  output logic [NUM_W-1:0]   out_numerator,
  output logic [FRAC_W-1:0]  out_fraction_digits,
  output logic               out_overflow,
  output logic               out_too_long,
  output logic [LINE_W-1:0]  out_line_number,
  output logic               out_last
);

  logic        in_vld_r;
  logic [7:0]  byte_r;
  logic        end_r;
  logic        advance, free;
  scan_out_t   scan_res;
  result_t     out_res;

  // Input register
  assign advance  = in_vld_r && free;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      end_r  <= in_at_end;
    end
  end

  // Scanner
  stk_scan #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .in_byte   (byte_r),
    .in_at_end (end_r),
    .res       (scan_res)
  );

  // Output register
  stk_out_pair u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (scan_res),
    .free      (free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  assign out_kind            = out_res.kind;
  assign out_char            = out_res.ch;
  assign out_numerator       = out_res.num;
  assign out_fraction_digits = out_res.frac;
  assign out_overflow        = out_res.ovf;
  assign out_too_long        = out_res.too_long;
  assign out_line_number     = out_res.line;

  // Checks
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_number != '0))
    else $error("line number is zero on a result beat");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fraction_digits <= FRAC_MAX))
    else $error("fraction digit count beyond range");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("second result beat missing");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && !free))
    else $error("input stalled without a pending beat");

endmodule

[hdl/stk_scan.sv]
// Scanner state and per-byte decode for the tokenizer.
// Depends on stk_pkg; instantiated by sexpr_tokenizer_unit.
module stk_scan
  import stk_pkg::*;
#(
  parameter int unsigned MAX_TOKEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic        in_at_end,
  output scan_out_t   res
);

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN);

  // State registers
  scan_mode_t         mode_r, mode_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [NUM_W-1:0]   val_r, val_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [1:0]         dots_r, dots_nxt;
  logic               numeric_r, numeric_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;

  // Decode
  logic        is_ws, is_hash, is_bs, sk_hit, is_digit;
  kind_t       sk_kind, sp_kind, cls_kind;
  logic [7:0]  esc_ch, ch;
  logic        emit_char, num_chk, emit_end, emit_sp, do_clear, bs_hit;
  logic [3:0]  digit;
  logic [NUM_W+3:0] prod;

  // Token fields after an optional clear
  logic [NUM_W-1:0]  b_val;
  logic [FRAC_W-1:0] b_frac;
  logic [1:0]        b_dots;
  logic              b_numeric;
  logic [LEN_W-1:0]  b_len;
  logic              b_ovf;

  always_comb begin
    is_ws   = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_LF);
    is_hash = (in_byte == CH_HASH);
    is_bs   = (in_byte == CH_BSLASH);
    is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    digit   = 4'(in_byte - CH_ZERO);
    sk_hit  = 1'b1;
    sk_kind = KIND_OPEN;
    unique case (in_byte)
      CH_OPEN:   sk_kind = KIND_OPEN;
      CH_CLOSE:  sk_kind = KIND_CLOSE;
      CH_QUOTE:  sk_kind = KIND_QUOTE;
      CH_BQUOTE: sk_kind = KIND_BACKQUOTE;
      CH_COMMA:  sk_kind = KIND_COMMA;
      default:   sk_hit  = 1'b0;
    endcase
    if (in_byte == CH_LOW_N) begin
      esc_ch = CH_LF;
    end else if (in_byte == CH_LOW_T) begin
      esc_ch = CH_TAB;
    end else begin
      esc_ch = in_byte;
    end
  end

  // Mode transitions and what the byte emits
  always_comb begin
    emit_char = 1'b0;
    num_chk   = 1'b0;
    ch        = in_byte;
    emit_end  = 1'b0;
    emit_sp   = 1'b0;
    sp_kind   = sk_kind;
    do_clear  = 1'b0;
    bs_hit    = 1'b0;
    mode_nxt  = mode_r;
    if (in_at_end) begin
      emit_end = (mode_r == MODE_TOKEN) || (mode_r == MODE_ESCAPE);
      emit_sp  = 1'b1;
      sp_kind  = KIND_END;
      mode_nxt = MODE_BETWEEN;
    end else begin
      unique case (mode_r)
        MODE_COMMENT: begin
          if (in_byte == CH_LF) mode_nxt = MODE_BETWEEN;
        end
        MODE_ESCAPE: begin
          emit_char = 1'b1;
          ch        = esc_ch;
          mode_nxt  = MODE_TOKEN;
        end
        MODE_TOKEN: begin
          if (is_ws) begin
            emit_end = 1'b1;
            mode_nxt = MODE_BETWEEN;
          end else if (is_hash) begin
            emit_end = 1'b1;
            mode_nxt = MODE_COMMENT;
          end else if (sk_hit) begin
            emit_end = 1'b1;
            emit_sp  = 1'b1;
            mode_nxt = MODE_BETWEEN;
          end else if (is_bs) begin
            bs_hit   = 1'b1;
            mode_nxt = MODE_ESCAPE;
          end else begin
            emit_char = 1'b1;
            num_chk   = 1'b1;
          end
        end
        MODE_BETWEEN: begin
          if (is_ws) begin
            mode_nxt = MODE_BETWEEN;
          end else if (is_hash) begin
            mode_nxt = MODE_COMMENT;
          end else if (sk_hit) begin
            emit_sp = 1'b1;
          end else if (is_bs) begin
            do_clear = 1'b1;
            bs_hit   = 1'b1;
            mode_nxt = MODE_ESCAPE;
          end else begin
            do_clear  = 1'b1;
            emit_char = 1'b1;
            num_chk   = 1'b1;
            mode_nxt  = MODE_TOKEN;
          end
        end
        default: mode_nxt = MODE_BETWEEN;
      endcase
    end
  end

  // Token accumulation: clear, then add the character
  always_comb begin
    if (do_clear || emit_end) begin
      b_val     = '0;
      b_frac    = '0;
      b_dots    = '0;
      b_numeric = 1'b1;
      b_len     = '0;
      b_ovf     = 1'b0;
    end else begin
      b_val     = val_r;
      b_frac    = frac_r;
      b_dots    = dots_r;
      b_numeric = numeric_r;
      b_len     = len_r;
      b_ovf     = ovf_r;
    end
    // value * 10 + digit, as two shifts and adds
    prod = {1'b0, b_val, 3'b000} + {3'b000, b_val, 1'b0} + {{(NUM_W){1'b0}}, digit};

    val_nxt     = b_val;
    frac_nxt    = b_frac;
    dots_nxt    = b_dots;
    numeric_nxt = b_numeric && !bs_hit;
    len_nxt     = b_len;
    ovf_nxt     = b_ovf;
    if (emit_char) begin
      if (b_len != LEN_MAX) len_nxt = b_len + 1'b1;
      if (num_chk && b_numeric) begin
        if (is_digit) begin
          if (|prod[NUM_W+3:NUM_W]) begin
            val_nxt = NUM_MAX;
            ovf_nxt = 1'b1;
          end else begin
            val_nxt = prod[NUM_W-1:0];
          end
          if (b_dots != 2'd0) begin
            if (b_frac < FRAC_MAX) begin
              frac_nxt = b_frac + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end else if (in_byte == CH_DOT) begin
          if (b_dots < DOT_MAX) dots_nxt = b_dots + 1'b1;
        end else begin
          numeric_nxt = 1'b0;
        end
      end
    end

    // Line counter
    line_nxt = line_r;
    if (!in_at_end && (in_byte == CH_LF) && (line_r != LINE_MAX)) begin
      line_nxt = line_r + 1'b1;
    end
  end

  // Token class at token end
  always_comb begin
    if (numeric_r && (dots_r == 2'd1) && (len_r == LEN_W'(1))) begin
      cls_kind = KIND_DOT;
    end else if (numeric_r && (dots_r <= 2'd1)) begin
      cls_kind = KIND_NUMBER;
    end else begin
      cls_kind = KIND_SYMBOL;
    end
  end

  // Result assembly
  always_comb begin
    res.first.kind     = sp_kind;
    res.first.ch       = '0;
    res.first.num      = '0;
    res.first.frac     = '0;
    res.first.ovf      = 1'b0;
    res.first.too_long = 1'b0;
    res.first.line     = line_r;
    res.second_kind    = sp_kind;
    if (emit_char) begin
      res.first.kind     = KIND_CHAR;
      res.first.ch       = ch;
      res.first.too_long = (len_nxt == LEN_MAX);
    end else if (emit_end) begin
      res.first.kind     = cls_kind;
      res.first.too_long = (len_r == LEN_MAX);
      if (cls_kind == KIND_NUMBER) begin
        res.first.num  = val_r;
        res.first.frac = frac_r;
        res.first.ovf  = ovf_r;
      end
    end
    if (emit_end && emit_sp) begin
      res.count = 2'd2;
    end else if (emit_char || emit_end || emit_sp) begin
      res.count = 2'd1;
    end else begin
      res.count = 2'd0;
    end
  end

  // State update on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BETWEEN;
      line_r    <= LINE_W'(1);
      val_r     <= '0;
      frac_r    <= '0;
      dots_r    <= '0;
      numeric_r <= 1'b1;
      len_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      line_r    <= line_nxt;
      val_r     <= val_nxt;
      frac_r    <= frac_nxt;
      dots_r    <= dots_nxt;
      numeric_r <= numeric_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

[hdl/stk_out_pair.sv]
// Output register for the tokenizer: holds the one or two result beats of
// one item and hands them out in order. Depends on stk_pkg.
module stk_out_pair
  import stk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  scan_out_t          res,
  output logic               free,
  input  logic               out_ready,
  output logic               out_valid,
  output result_t            out_res,
  output logic               out_last
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       idx_r, idx_nxt;
  result_t    first_r;
  kind_t      second_r;
  logic       pop, final_beat;

  // Beat selection
  always_comb begin
    out_valid  = (cnt_r != 2'd0);
    final_beat = idx_r || (cnt_r == 2'd1);
    out_last   = final_beat;
    pop        = out_valid && out_ready;
    free       = !out_valid || (pop && final_beat);
    out_res    = first_r;
    if (idx_r) begin
      out_res.kind     = second_r;
      out_res.ch       = '0;
      out_res.num      = '0;
      out_res.frac     = '0;
      out_res.ovf      = 1'b0;
      out_res.too_long = 1'b0;
    end
  end

  // Count and index
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = res.count;
      idx_nxt = 1'b0;
    end else if (pop) begin
      if (final_beat) begin
        cnt_nxt = 2'd0;
        idx_nxt = 1'b0;
      end else begin
        idx_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      first_r  <= res.first;
      second_r <= res.second_kind;
    end
  end

endmodule

[tb/token_checker.sv]
// Result checker for the S-expression tokenizer: predicts the beats of every
// accepted input beat and compares the result channel against them in order.
// Depends on stk_pkg.
module token_checker
  import stk_pkg::*;
#(
  parameter int unsigned TOKEN_LIMIT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_at_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         out_kind,
  input  logic [7:0]         out_char,
  input  logic [NUM_W-1:0]   out_numerator,
  input  logic [FRAC_W-1:0]  out_fraction_digits,
  input  logic               out_overflow,
  input  logic               out_too_long,
  input  logic [LINE_W-1:0]  out_line_number,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    kind_t              kind;
    logic [7:0]         ch;
    logic [NUM_W-1:0]   num;
    logic [FRAC_W-1:0]  frac;
    logic               ovf;
    logic               too_long;
    logic [LINE_W-1:0]  line;
    logic               last;
  } token_beat_t;

  token_beat_t expected_beats[$];
  token_beat_t head_beat;

  // Predicted lexer state
  scan_mode_t         lex_mode;
  logic [LINE_W-1:0]  cur_line;
  logic [NUM_W-1:0]   digit_value;
  logic [FRAC_W-1:0]  frac_ctr;
  logic [1:0]         dot_ctr;
  logic               only_digits;
  int unsigned        tok_len;
  logic               num_sat;

  function automatic void expect_beat(kind_t k, logic [7:0] ch, logic [NUM_W-1:0] num,
                                      logic [FRAC_W-1:0] frac, logic ovf, logic tl);
    token_beat_t b;
    b.kind     = k;
    b.ch       = ch;
    b.num      = num;
    b.frac     = frac;
    b.ovf      = ovf;
    b.too_long = tl;
    b.line     = cur_line;
    b.last     = 1'b0;
    expected_beats.push_back(b);
  endfunction

  function automatic logic overlong();
    return tok_len > TOKEN_LIMIT - 1;
  endfunction

  function automatic void clear_token();
    digit_value = '0;
    frac_ctr    = '0;
    dot_ctr     = '0;
    only_digits = 1'b1;
    tok_len     = 0;
    num_sat     = 1'b0;
  endfunction

  // One emitted token character; numeric tracking only for unescaped bytes
  function automatic void take_char(logic [7:0] ch, bit numeric);
    logic [NUM_W-1:0] d;
    if (tok_len < TOKEN_LIMIT) tok_len++;
    if (numeric && only_digits) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        d = NUM_W'(ch - CH_ZERO);
        if (digit_value > (NUM_MAX - d) / 10) begin
          digit_value = NUM_MAX;
          num_sat     = 1'b1;
        end else begin
          digit_value = digit_value * 10 + d;
        end
        if (dot_ctr > 0) begin
          if (frac_ctr < FRAC_MAX) frac_ctr++;
          else num_sat = 1'b1;
        end
      end else if (ch == CH_DOT) begin
        if (dot_ctr < DOT_MAX) dot_ctr++;
      end else begin
        only_digits = 1'b0;
      end
    end
    expect_beat(KIND_CHAR, ch, '0, '0, 1'b0, overlong());
  endfunction

  // Class beat at token end: lone dot, number or symbol
  function automatic void finish_token();
    logic tl;
    tl = overlong();
    if (only_digits && dot_ctr == 1 && tok_len == 1)
      expect_beat(KIND_DOT, '0, '0, '0, 1'b0, tl);
    else if (only_digits && dot_ctr <= 1)
      expect_beat(KIND_NUMBER, '0, digit_value, frac_ctr, num_sat, tl);
    else
      expect_beat(KIND_SYMBOL, '0, '0, '0, 1'b0, tl);
    clear_token();
  endfunction

  function automatic bit special_kind(input logic [7:0] b, output kind_t k);
    special_kind = 1'b1;
    k = KIND_OPEN;
    case (b)
      CH_OPEN:   k = KIND_OPEN;
      CH_CLOSE:  k = KIND_CLOSE;
      CH_QUOTE:  k = KIND_QUOTE;
      CH_BQUOTE: k = KIND_BACKQUOTE;
      CH_COMMA:  k = KIND_COMMA;
      default:   special_kind = 1'b0;
    endcase
  endfunction

  function automatic void predict(logic [7:0] b, logic at_end);
    int          first;
    bit          ws;
    bit          sp;
    kind_t       sk;
    token_beat_t tail;
    first = expected_beats.size();
    if (at_end) begin
      if (lex_mode == MODE_TOKEN || lex_mode == MODE_ESCAPE) finish_token();
      expect_beat(KIND_END, '0, '0, '0, 1'b0, 1'b0);
      lex_mode = MODE_BETWEEN;
    end else begin
      ws = (b == CH_SPACE || b == CH_TAB || b == CH_LF);
      sp = special_kind(b, sk);
      case (lex_mode)
        MODE_COMMENT: begin
          if (b == CH_LF) lex_mode = MODE_BETWEEN;
        end
        MODE_ESCAPE: begin
          take_char(b == CH_LOW_N ? CH_LF : (b == CH_LOW_T ? CH_TAB : b), 1'b0);
          lex_mode = MODE_TOKEN;
        end
        MODE_TOKEN: begin
          if (ws) begin
            finish_token();
            lex_mode = MODE_BETWEEN;
          end else if (b == CH_HASH) begin
            finish_token();
            lex_mode = MODE_COMMENT;
          end else if (sp) begin
            finish_token();
            expect_beat(sk, '0, '0, '0, 1'b0, 1'b0);
            lex_mode = MODE_BETWEEN;
          end else if (b == CH_BSLASH) begin
            only_digits = 1'b0;
            lex_mode    = MODE_ESCAPE;
          end else begin
            take_char(b, 1'b1);
          end
        end
        default: begin
          if (ws) begin
            // skipped
          end else if (b == CH_HASH) begin
            lex_mode = MODE_COMMENT;
          end else if (sp) begin
            expect_beat(sk, '0, '0, '0, 1'b0, 1'b0);
          end else if (b == CH_BSLASH) begin
            clear_token();
            only_digits = 1'b0;
            lex_mode    = MODE_ESCAPE;
          end else begin
            clear_token();
            take_char(b, 1'b1);
            lex_mode = MODE_TOKEN;
          end
        end
      endcase
      // a newline belongs to the line it ends
      if (b == CH_LF && cur_line < LINE_MAX) cur_line++;
    end
    if (expected_beats.size() > first) begin
      tail = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Track input beats, then compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      lex_mode   = MODE_BETWEEN;
      cur_line   = 16'd1;
      clear_token();
      expected_beats.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) predict(in_byte, in_at_end);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d", out_kind);
          fail_count++;
        end else begin
          head_beat = expected_beats.pop_front();
          check_field("kind", head_beat.kind, out_kind);
          check_field("char", head_beat.ch, out_char);
          check_field("numerator", head_beat.num, out_numerator);
          check_field("fraction_digits", head_beat.frac, out_fraction_digits);
          check_field("overflow", head_beat.ovf, out_overflow);
          check_field("too_long", head_beat.too_long, out_too_long);
          check_field("line_number", head_beat.line, out_line_number);
          check_field("last", head_beat.last, out_last);
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for sexpr_tokenizer_unit: clock, reset, source byte stimulus,
// result back-pressure and the final verdict.
// Depends on stk_pkg, sexpr_tokenizer_unit and token_checker.
module tb;
  import stk_pkg::*;

  localparam int unsigned TOKEN_LIMIT  = 1024;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          PHASE_ITEMS  = 170;
  localparam logic [7:0]  CH_LOW_A     = 8'h61;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte   = '0;
  logic               in_at_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_kind;
  logic [7:0]         out_char;
  logic [NUM_W-1:0]   out_numerator;
  logic [FRAC_W-1:0]  out_fraction_digits;
  logic               out_overflow;
  logic               out_too_long;
  logic [LINE_W-1:0]  out_line_number;
  logic               out_last;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  // source stream: {at_end, byte}
  logic [8:0] src_items[$];

  sexpr_tokenizer_unit #(.MAX_TOKEN(TOKEN_LIMIT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_at_end(in_at_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind), .out_char(out_char),
    .out_numerator(out_numerator), .out_fraction_digits(out_fraction_digits),
    .out_overflow(out_overflow), .out_too_long(out_too_long),
    .out_line_number(out_line_number), .out_last(out_last)
  );

  token_checker #(.TOKEN_LIMIT(TOKEN_LIMIT)) token_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_at_end(in_at_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind), .out_char(out_char),
    .out_numerator(out_numerator), .out_fraction_digits(out_fraction_digits),
    .out_overflow(out_overflow), .out_too_long(out_too_long),
    .out_line_number(out_line_number), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void put_byte(logic [7:0] b);
    src_items.push_back({1'b0, b});
  endfunction

  // end marker carries a random, ignored byte
  function automatic void put_end();
    src_items.push_back({1'b1, 8'($urandom)});
  endfunction

  function automatic logic [7:0] digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // printable token byte that neither delimits nor escapes
  function automatic logic [7:0] sym_char();
    logic [7:0] c;
    do c = 8'($urandom_range(126, 33));
    while (c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE || c == CH_BQUOTE ||
           c == CH_COMMA || c == CH_HASH || c == CH_BSLASH);
    return c;
  endfunction

  function automatic void put_special();
    case ($urandom_range(4))
      0: put_byte(CH_OPEN);
      1: put_byte(CH_CLOSE);
      2: put_byte(CH_QUOTE);
      3: put_byte(CH_BQUOTE);
      default: put_byte(CH_COMMA);
    endcase
  endfunction

  // usually end a token with whitespace or a special; sometimes let it run on
  function automatic void maybe_separate();
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(3))
        0: put_byte(CH_SPACE);
        1: put_byte(CH_LF);
        2: put_byte(CH_TAB);
        default: put_special();
      endcase
    end
  endfunction

  // One well-formed lexeme with random content, or a little noise
  function automatic void put_lexeme();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      repeat ($urandom_range(8, 1)) put_byte(digit());
      if ($urandom_range(1)) begin
        put_byte(CH_DOT);
        repeat ($urandom_range(4)) put_byte(digit());
      end
      maybe_separate();
    end else if (sel < 24) begin
      // numerator or fraction digit saturation
      if ($urandom_range(1)) begin
        repeat ($urandom_range(22, 18)) put_byte(digit());
      end else begin
        put_byte(digit());
        put_byte(CH_DOT);
        repeat ($urandom_range(21, 16)) put_byte(digit());
      end
      maybe_separate();
    end else if (sel < 27) begin
      put_byte(CH_DOT);
      maybe_separate();
    end else if (sel < 30) begin
      case ($urandom_range(2))
        0: begin
          put_byte(digit()); put_byte(CH_DOT); put_byte(digit());
          put_byte(CH_DOT); put_byte(digit());
        end
        1: begin put_byte(CH_DOT); put_byte(CH_DOT); end
        default: begin put_byte(CH_DOT); put_byte(digit()); put_byte(digit()); end
      endcase
      maybe_separate();
    end else if (sel < 45) begin
      repeat ($urandom_range(6, 1)) put_byte(sym_char());
      maybe_separate();
    end else if (sel < 52) begin
      repeat ($urandom_range(2)) put_byte(sym_char());
      put_byte(CH_BSLASH);
      case ($urandom_range(3))
        0: put_byte(CH_LOW_N);
        1: put_byte(CH_LOW_T);
        2: put_byte(CH_LF);
        default: put_byte(8'($urandom));
      endcase
      repeat ($urandom_range(2)) put_byte(sym_char());
      maybe_separate();
    end else if (sel < 68) begin
      put_special();
    end else if (sel < 78) begin
      case ($urandom_range(2))
        0: put_byte(CH_SPACE);
        1: put_byte(CH_TAB);
        default: put_byte(CH_LF);
      endcase
    end else if (sel < 83) begin
      put_byte(CH_HASH);
      repeat ($urandom_range(4)) put_byte(8'($urandom));
      put_byte(CH_LF);
    end else if (sel < 86) begin
      put_end();
    end else if (sel < 89) begin
      // backslash then end of input
      repeat ($urandom_range(2)) put_byte(sym_char());
      put_byte(CH_BSLASH);
      put_end();
    end else begin
      repeat ($urandom_range(3, 1)) put_byte(8'($urandom));
    end
  endfunction

  task automatic send_item(logic [8:0] item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_at_end <= item[8];
    in_byte   <= item[7:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_all();
    foreach (src_items[i]) send_item(src_items[i]);
    src_items.delete();
  endtask

  // hold the sender off until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int tok_n;
    int base;
    bit digits_only;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: specials, lone dot, number before a close, comment, escapes,
    // escaped newline, byte extremes, backslash then end, end inside a token
    put_byte(CH_OPEN);   put_byte(CH_CLOSE);  put_byte(CH_QUOTE);
    put_byte(CH_BQUOTE); put_byte(CH_COMMA);
    put_byte(CH_DOT);    put_byte(CH_SPACE);
    put_byte(CH_ZERO + 8'd1); put_byte(CH_DOT); put_byte(CH_ZERO + 8'd5); put_byte(CH_CLOSE);
    put_byte(CH_HASH);   put_byte(CH_LOW_A);  put_byte(CH_LF);
    put_byte(CH_BSLASH); put_byte(CH_LOW_N);
    put_byte(CH_BSLASH); put_byte(CH_LF);
    put_byte(CH_BSLASH); put_byte(CH_LOW_T);
    put_byte(8'h00);     put_byte(8'hFF);     put_byte(CH_TAB);
    put_byte(CH_BSLASH); put_end();
    put_byte(CH_NINE);   put_end();
    send_all();
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 8;  recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 2) begin
        // one long token, from three below the length limit to five past it
        tok_n = TOKEN_LIMIT - 3 + $urandom_range(8);
        digits_only = 1'($urandom_range(1));
        repeat (tok_n) put_byte(digits_only ? digit() : sym_char());
        put_byte(CH_CLOSE);
      end
      base = src_items.size();
      while (src_items.size() < base + PHASE_ITEMS) put_lexeme();
      send_all();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
hdl/stk_pkg.sv
hdl/stk_scan.sv
hdl/stk_out_pair.sv
hdl/sexpr_tokenizer_unit.sv
tb/token_checker.sv
tb/tb.sv
